### design/rotated_polygon_point_test_unit_assert.svh
// Assertion macros shared by the rotated polygon point test unit.
`ifndef ROTATED_POLYGON_POINT_TEST_UNIT_ASSERT_SVH
`define ROTATED_POLYGON_POINT_TEST_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RPPT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RPPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/rppt_pkg.sv
// Types, widths and helpers for the rotated polygon point test unit.
`timescale 1ns / 1ps

package rppt_pkg;

  // Default polygon store depth
  localparam int MAX_POLY_VERTICES_DEF = 16;

  // Extra rows the test ray reaches past the box top
  localparam int RAY_EXTRA = 5;

  // Field widths
  localparam int ROT_CS_W   = 16;  // Q2.14 cosine / sine
  localparam int COORD_W    = 13;  // anchor and point coordinates
  localparam int RAD_W      = 9;
  localparam int VCNT_W     = 5;
  localparam int OFF_W      = 10;
  localparam int VIDX_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Internal arithmetic widths
  localparam int ROT_W   = 14;           // rotated vertex coordinate
  localparam int NOFF_W  = OFF_W + 1;    // negated offset
  localparam int DIF_W   = 15;           // coordinate differences
  localparam int MA_W    = 16;           // multiplier operand a
  localparam int MB_W    = 15;           // multiplier operand b
  localparam int PROD_W  = MA_W + MB_W;  // product
  localparam int ACC_W   = 29;           // rotation accumulator

  localparam int Q14_SHIFT = 14;
  localparam int Q14_ROUND = (1 << Q14_SHIFT) - 1;

  // Register reset values
  localparam int COS_RESET  = 16384;
  localparam int VCNT_RESET = 3;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS    = 3'd0,
    REG_SIN    = 3'd1,
    REG_ANCH_X = 3'd2,
    REG_ANCH_Y = 3'd3,
    REG_RADIUS = 3'd4,
    REG_VCOUNT = 3'd5
  } cfg_reg_e;

  // Item action codes
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_TEST = 1'b1
  } action_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RD,
    ST_ROT0,
    ST_ROT1,
    ST_ROT2,
    ST_ROT3,
    ST_ROT4,
    ST_ROT5,
    ST_SAVE,
    ST_E0,
    ST_E1,
    ST_E2,
    ST_E3,
    ST_FIN
  } state_e;

  // Divide a Q14 accumulator by 2^14, rounding toward zero
  function automatic logic signed [ROT_W-1:0] trunc_q14(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + (v[ACC_W-1] ? ACC_W'(Q14_ROUND) : ACC_W'(0));
    return t[Q14_SHIFT+ROT_W-1:Q14_SHIFT];
  endfunction

endpackage

### design/rotated_polygon_point_test_unit.sv
// Rotated polygon point test: vertex store, rotation and ray crossing sequencer.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+-------------------------------------
//  in      | input     | in_valid_i / in_ready_o   | action, vertex_index, offsets, point
//  out     | output    | out_valid_o / out_ready_i | inside_res
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A load word is taken while the unit is idle and writes one vertex slot if its index is below MAX_POLY_VERTICES.
// A test word runs one pass over the n vertices in use, or goes straight to its result
// when the point misses the box or n is zero; one shared 16x15 multiplier does the
// four rotation products per vertex and three cross products per edge.
// The input is not ready while a test runs; the result register lets the next word in
// while a result waits, and a finished test holds until that register is free.
// Reset is asynchronous and needs no clearing pass; the vertex store is undefined
// until written.
`timescale 1ns / 1ps

`include "rotated_polygon_point_test_unit_assert.svh"

module rotated_polygon_point_test_unit
  import rppt_pkg::*;
#(
  parameter int MAX_POLY_VERTICES = MAX_POLY_VERTICES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input words
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         action_i,
  input  logic [VIDX_W-1:0]            vertex_index_i,
  input  logic signed [OFF_W-1:0]      offset_x_i,
  input  logic signed [OFF_W-1:0]      offset_y_i,
  input  logic signed [COORD_W-1:0]    point_x_i,
  input  logic signed [COORD_W-1:0]    point_y_i,
  // result words
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         inside_res_o,
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int AW = (MAX_POLY_VERTICES > 1) ? $clog2(MAX_POLY_VERTICES) : 1;
  localparam int CW = $clog2(MAX_POLY_VERTICES + 1);

  // configuration registers
  logic signed [ROT_CS_W-1:0] cos_q, sin_q;
  logic signed [COORD_W-1:0]  anch_x_q, anch_y_q;
  logic [RAD_W-1:0]           radius_q;
  logic [VCNT_W-1:0]          vcount_q;

  // sequencer
  state_e                     state_q, state_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [CW-1:0]              n_q, n_d;
  logic                       par_q, par_d;
  logic                       out_valid_q, out_valid_d;
  logic                       res_q, res_d;

  // datapath
  logic signed [COORD_W-1:0]  px_q, py_q;
  logic signed [ROT_W-1:0]    ray_q, ray_d;
  logic signed [OFF_W-1:0]    rx_q, ry_q;
  logic signed [MA_W-1:0]     mul_a;
  logic signed [MB_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic signed [PROD_W-1:0]   t_q, t_d;
  logic signed [PROD_W-1:0]   side_diff;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [ROT_W-1:0]    x0_q, y0_q, x1_q, y1_q, xf_q, yf_q;
  logic signed [ROT_W-1:0]    x0_d, y0_d, x1_d, y1_d, xf_d, yf_d;
  logic                       dc_pos_q, dc_neg_q, dc_pos_d, dc_neg_d;
  logic                       eok_q, eok_d;

  // vertex store
  logic signed [OFF_W-1:0]    mem_x [MAX_POLY_VERTICES];
  logic signed [OFF_W-1:0]    mem_y [MAX_POLY_VERTICES];
  logic                       mem_we;

  // handshake
  logic                       in_fire;
  logic                       test_fire;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;
  assign test_fire    = in_fire && (action_i == ACT_TEST);
  assign mem_we       = in_fire && (action_i == ACT_LOAD) &&
                        (32'(vertex_index_i) < MAX_POLY_VERTICES);
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign inside_res_o = res_q;

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q    <= ROT_CS_W'(COS_RESET);
      sin_q    <= '0;
      anch_x_q <= '0;
      anch_y_q <= '0;
      radius_q <= '0;
      vcount_q <= VCNT_W'(VCNT_RESET);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_COS:    cos_q    <= $signed(cfg_data_i);
        REG_SIN:    sin_q    <= $signed(cfg_data_i);
        REG_ANCH_X: anch_x_q <= $signed(cfg_data_i[COORD_W-1:0]);
        REG_ANCH_Y: anch_y_q <= $signed(cfg_data_i[COORD_W-1:0]);
        REG_RADIUS: radius_q <= cfg_data_i[RAD_W-1:0];
        REG_VCOUNT: vcount_q <= cfg_data_i[VCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // vertex store: one write port, one registered read at the vertex counter
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_x[AW'(vertex_index_i)] <= offset_x_i;
      mem_y[AW'(vertex_index_i)] <= offset_y_i;
    end
    rx_q <= mem_x[cnt_q[AW-1:0]];
    ry_q <= mem_y[cnt_q[AW-1:0]];
  end

  // box test terms
  logic signed [ROT_W-1:0] rad_s, px_w, py_w;
  logic                    in_box;
  assign rad_s  = $signed(ROT_W'(radius_q));
  assign px_w   = ROT_W'(px_q);
  assign py_w   = ROT_W'(py_q);
  assign in_box = (px_w >= ROT_W'(anch_x_q) - rad_s) && (px_w <= ROT_W'(anch_x_q) + rad_s) &&
                  (py_w >= ROT_W'(anch_y_q) - rad_s) && (py_w <= ROT_W'(anch_y_q) + rad_s);

  // edge and rotation operands
  logic signed [NOFF_W-1:0] ndx, ndy;
  logic signed [DIF_W-1:0]  ex, ey, px_x0, px_x1, ray_y0, py_y0;
  logic                     xs0_pos, xs0_neg, xs1_pos, xs1_neg;
  assign ndx    = -(NOFF_W'(rx_q));
  assign ndy    = -(NOFF_W'(ry_q));
  assign ex     = DIF_W'(x1_q) - DIF_W'(x0_q);
  assign ey     = DIF_W'(y1_q) - DIF_W'(y0_q);
  assign px_x0  = DIF_W'(px_q) - DIF_W'(x0_q);
  assign px_x1  = DIF_W'(px_q) - DIF_W'(x1_q);
  assign ray_y0 = DIF_W'(ray_q) - DIF_W'(y0_q);
  assign py_y0  = DIF_W'(py_q) - DIF_W'(y0_q);
  // edge ends against the vertical ray line (sign of x - px)
  assign xs0_pos = px_x0[DIF_W-1];
  assign xs0_neg = !px_x0[DIF_W-1] && (px_x0 != '0);
  assign xs1_pos = px_x1[DIF_W-1];
  assign xs1_neg = !px_x1[DIF_W-1] && (px_x1 != '0);

  // shared multiplier
  assign prod_d    = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign side_diff = t_q - prod_q;

  // next state and datapath control
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    par_d       = par_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ray_d       = ray_q;
    acc_d       = acc_q;
    t_d         = t_q;
    x0_d        = x0_q;
    y0_d        = y0_q;
    x1_d        = x1_q;
    y1_d        = y1_q;
    xf_d        = xf_q;
    yf_d        = yf_q;
    dc_pos_d    = dc_pos_q;
    dc_neg_d    = dc_neg_q;
    eok_d       = eok_q;
    mul_a       = '0;
    mul_b       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (test_fire) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        n_d   = (32'(vcount_q) > MAX_POLY_VERTICES) ? CW'(MAX_POLY_VERTICES) : CW'(vcount_q);
        ray_d = ROT_W'(anch_y_q) + rad_s + ROT_W'(RAY_EXTRA);
        cnt_d = '0;
        par_d = 1'b0;
        if (!in_box || (n_d == '0)) state_d = ST_FIN;
        else state_d = ST_RD;
      end
      // store read in flight
      ST_RD: state_d = ST_ROT0;
      // x = ax*2^14 - cos*dx + sin*dy, y = ay*2^14 - sin*dx - cos*dy (products taken on the negated offsets)
      ST_ROT0: begin
        mul_a   = cos_q;
        mul_b   = MB_W'(ndx);
        state_d = ST_ROT1;
      end
      ST_ROT1: begin
        mul_a   = sin_q;
        mul_b   = MB_W'(ndy);
        acc_d   = (ACC_W'(anch_x_q) <<< Q14_SHIFT) + ACC_W'(prod_q);
        state_d = ST_ROT2;
      end
      ST_ROT2: begin
        mul_a   = sin_q;
        mul_b   = MB_W'(ndx);
        acc_d   = acc_q - ACC_W'(prod_q);
        state_d = ST_ROT3;
      end
      ST_ROT3: begin
        mul_a   = cos_q;
        mul_b   = MB_W'(ndy);
        x1_d    = trunc_q14(acc_q);
        acc_d   = (ACC_W'(anch_y_q) <<< Q14_SHIFT) + ACC_W'(prod_q);
        state_d = ST_ROT4;
      end
      ST_ROT4: begin
        acc_d   = acc_q + ACC_W'(prod_q);
        state_d = ST_ROT5;
      end
      ST_ROT5: begin
        y1_d    = trunc_q14(acc_q);
        state_d = (cnt_q == '0) ? ST_SAVE : ST_E0;
      end
      // first vertex: keep it for the closing edge
      ST_SAVE: begin
        xf_d    = x1_q;
        yf_d    = y1_q;
        x0_d    = x1_q;
        y0_d    = y1_q;
        cnt_d   = CW'(1);
        state_d = (n_q == CW'(1)) ? ST_E0 : ST_RD;
      end
      // edge test: ray ends on each side of the edge, edge ends on each side of the ray
      ST_E0: begin
        mul_a   = MA_W'(ey);
        mul_b   = px_x0;
        eok_d   = !((xs0_pos && xs1_pos) || (xs0_neg && xs1_neg)) &&
                  (x0_q != x1_q) && (py_w != ray_q);
        state_d = ST_E1;
      end
      ST_E1: begin
        mul_a   = MA_W'(ex);
        mul_b   = ray_y0;
        t_d     = prod_q;
        state_d = ST_E2;
      end
      ST_E2: begin
        mul_a    = MA_W'(ex);
        mul_b    = py_y0;
        dc_pos_d = !side_diff[PROD_W-1] && (side_diff != '0);
        dc_neg_d = side_diff[PROD_W-1];
        state_d  = ST_E3;
      end
      ST_E3: begin
        if (eok_q &&
            !((dc_pos_q && !side_diff[PROD_W-1] && (side_diff != '0)) ||
              (dc_neg_q && side_diff[PROD_W-1]))) begin
          par_d = !par_q;
        end
        x0_d = x1_q;
        y0_d = y1_q;
        if (cnt_q == n_q) begin
          state_d = ST_FIN;
        end else if (cnt_q + CW'(1) == n_q) begin
          x1_d    = xf_q;
          y1_d    = yf_q;
          cnt_d   = cnt_q + CW'(1);
          state_d = ST_E0;
        end else begin
          cnt_d   = cnt_q + CW'(1);
          state_d = ST_RD;
        end
      end
      // hand the result to the output register once it is free
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          res_d       = par_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      n_q         <= '0;
      par_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      par_q       <= par_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (test_fire) begin
      px_q <= point_x_i;
      py_q <= point_y_i;
    end
    res_q    <= res_d;
    ray_q    <= ray_d;
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    t_q      <= t_d;
    x0_q     <= x0_d;
    y0_q     <= y0_d;
    x1_q     <= x1_d;
    y1_q     <= y1_d;
    xf_q     <= xf_d;
    yf_q     <= yf_d;
    dc_pos_q <= dc_pos_d;
    dc_neg_q <= dc_neg_d;
    eok_q    <= eok_d;
  end

  // checks
  `RPPT_ASSERT_IMPL(a_result_from_fin, $rose(out_valid_q), $past(state_q) == ST_FIN, "result without finished test")
  `RPPT_ASSERT_IMPL(a_cnt_in_range, state_q != ST_IDLE, cnt_q <= n_q, "vertex counter past count")
  `RPPT_ASSERT_IMPL(a_edge_cnt_nonzero, state_q == ST_E0, cnt_q != '0, "edge test before first vertex")
  `RPPT_ASSERT_NEXT(a_fin_delivers, (state_q == ST_FIN) && (!out_valid_q || out_ready_i), out_valid_q && (res_q == $past(par_q)), "finished test not delivered")

endmodule
